[design/tvvc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tvvc_pkg;

  // Polygon storage and number format.
  localparam int unsigned MAX_POLY_VERTS = 9;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned COL_W          = 17;
  localparam int unsigned VWORDS         = 10;
  localparam int unsigned NUM_PLANES     = 6;
  localparam int unsigned RAM_DEPTH      = 2 * MAX_POLY_VERTS;
  localparam int unsigned RAM_AW         = $clog2(RAM_DEPTH);

  // Word positions inside a stored vertex.
  localparam int unsigned W_X  = 0;
  localparam int unsigned W_Y  = 1;
  localparam int unsigned W_Z  = 2;
  localparam int unsigned W_R  = 3;
  localparam int unsigned W_G  = 4;
  localparam int unsigned W_B  = 5;
  localparam int unsigned W_A  = 6;
  localparam int unsigned W_NX = 7;
  localparam int unsigned W_NY = 8;
  localparam int unsigned W_NZ = 9;

  typedef logic [VWORDS-1:0][WORD_W-1:0] vert_t;
  typedef logic [RAM_AW-1:0]             addr_t;
  typedef logic [3:0]                    idx_t;
  typedef logic [2:0]                    plane_t;
  typedef logic [FRAC_BITS:0]            ratio_t;

  localparam ratio_t ONE_Q = ratio_t'(1) << FRAC_BITS;
  localparam plane_t LAST_PLANE = plane_t'(NUM_PLANES - 1);

  localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;
  localparam logic signed [34:0] ONE_W   = 35'sd65536;

  // Request to and answer from the ratio divider.
  typedef struct packed {
    logic        start;
    logic [32:0] num;
    logic [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic   done;
    ratio_t q;
  } div_rsp_t;

  // Saturate a wide signed sum to one signed word.
  function automatic logic [WORD_W-1:0] sat_word(logic signed [34:0] v);
    logic [WORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[WORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Axis that a clip plane tests.
  function automatic idx_t plane_axis(plane_t p);
    idx_t a;
    case (p)
      3'd0:    a = idx_t'(W_Y);
      3'd1:    a = idx_t'(W_X);
      3'd2:    a = idx_t'(W_Z);
      3'd3:    a = idx_t'(W_X);
      3'd4:    a = idx_t'(W_Y);
      default: a = idx_t'(W_Z);
    endcase
    return a;
  endfunction

  // Signed distance of a vertex to a plane; positive means inside.
  function automatic logic [WORD_W-1:0] plane_dist(vert_t v, plane_t p);
    logic [WORD_W-1:0] c;
    logic signed [34:0] ce;
    logic signed [34:0] d;
    c  = v[plane_axis(p)];
    ce = $signed({{3{c[WORD_W-1]}}, c});
    if (p < 3'd3) begin
      d = ONE_W - ce;
    end else begin
      d = ce + ONE_W;
    end
    return sat_word(d);
  endfunction

  // Buffer address of vertex idx in buffer sel.
  function automatic addr_t vert_addr(logic sel, idx_t idx);
    addr_t a;
    if (sel) begin
      a = addr_t'(MAX_POLY_VERTS) + addr_t'(idx);
    end else begin
      a = addr_t'(idx);
    end
    return a;
  endfunction

endpackage

`default_nettype wire

[design/tvvc_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one vertex per item.
interface tvvc_vtx_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [16:0] col_r;
  logic [16:0] col_g;
  logic [16:0] col_b;
  logic [16:0] col_a;
  logic [31:0] nrm_x;
  logic [31:0] nrm_y;
  logic [31:0] nrm_z;

  modport source (output valid, pos_x, pos_y, pos_z, col_r, col_g, col_b, col_a,
                  nrm_x, nrm_y, nrm_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, col_r, col_g, col_b, col_a,
                nrm_x, nrm_y, nrm_z, output ready);
endinterface

// Output channel: one clipped vertex per item.
interface tvvc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [16:0] out_r;
  logic [16:0] out_g;
  logic [16:0] out_b;
  logic [16:0] out_a;
  logic [31:0] out_nx;
  logic [31:0] out_ny;
  logic [31:0] out_nz;
  logic        last_of_run;

  modport source (output valid, out_x, out_y, out_z, out_r, out_g, out_b, out_a,
                  out_nx, out_ny, out_nz, last_of_run, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_r, out_g, out_b, out_a,
                out_nx, out_ny, out_nz, last_of_run, output ready);
endinterface

`default_nettype wire

[design/triangle_view_volume_clipper.sv]
`timescale 1ns / 1ps
`default_nettype none

// The first two vertices of a triangle only go into the polygon buffer. The
// third starts six clip passes, during which the input is not ready. Each plane
// crossing uses the shared restoring divider for the crossing ratio and the
// single shared multiplier for each word of the new vertex. The surviving
// polygon is then sent as a fan. Polygons are held in a two-bank vertex RAM
// that needs no clearing after reset.
module triangle_view_volume_clipper (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tvvc_vtx_if.sink   vtx_i,
  tvvc_res_if.source res_o
);

  typedef enum logic [3:0] {
    IDLE, P_RD0, P_LD0, P_LDC, EDGE, DIV_WAIT, L_MUL, L_ADD,
    W_XV, PUSH_CUR, NEXT_PASS, E_RD, E_LD, E_WAIT
  } state_e;

  state_e                 state_q;
  logic [1:0]             vcount_q;
  tvvc_pkg::idx_t         n_q, cnt_q, j_q, k_q, i_q;
  tvvc_pkg::plane_t       pass_q;
  logic                   src_q;
  logic                   closing_q;
  logic                   in2_q;
  logic [1:0]             phase_q;
  logic                   res_valid_q;
  logic                   res_last_q;
  tvvc_pkg::vert_t        first_q, prev_q, cur_q, x_q, res_q;
  tvvc_pkg::ratio_t       t_q;
  logic [49:0]            prod_q;
  logic                   neg_q;

  logic                   we;
  tvvc_pkg::addr_t        waddr, raddr;
  tvvc_pkg::vert_t        wdata, rdata, in_vert;
  tvvc_pkg::div_req_t     div_req;
  tvvc_pkg::div_rsp_t     div_rsp;
  logic [31:0]            d1, d2;
  logic signed [32:0]     d1e;
  logic signed [33:0]     den;
  logic                   in1, in2;
  logic                   room;
  logic                   accept;
  logic [31:0]            p1, p2;
  logic signed [32:0]     diff;
  logic [32:0]            mag;
  logic [34:0]            qv;
  logic signed [34:0]     sum;
  tvvc_pkg::idx_t         fan_idx;

  // Polygon buffers: bank 0 and bank 1.
  tvvc_ram #(
    .WIDTH($bits(tvvc_pkg::vert_t)),
    .DEPTH(tvvc_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  tvvc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign accept      = vtx_i.valid && vtx_i.ready;
  assign vtx_i.ready = (state_q == IDLE);
  assign room        = cnt_q < tvvc_pkg::idx_t'(tvvc_pkg::MAX_POLY_VERTS);

  // Incoming vertex as stored; colours are kept zero-extended.
  always_comb begin
    in_vert                 = '0;
    in_vert[tvvc_pkg::W_X]  = vtx_i.pos_x;
    in_vert[tvvc_pkg::W_Y]  = vtx_i.pos_y;
    in_vert[tvvc_pkg::W_Z]  = vtx_i.pos_z;
    in_vert[tvvc_pkg::W_R]  = {15'd0, vtx_i.col_r};
    in_vert[tvvc_pkg::W_G]  = {15'd0, vtx_i.col_g};
    in_vert[tvvc_pkg::W_B]  = {15'd0, vtx_i.col_b};
    in_vert[tvvc_pkg::W_A]  = {15'd0, vtx_i.col_a};
    in_vert[tvvc_pkg::W_NX] = vtx_i.nrm_x;
    in_vert[tvvc_pkg::W_NY] = vtx_i.nrm_y;
    in_vert[tvvc_pkg::W_NZ] = vtx_i.nrm_z;
  end

  // Plane distances of the current edge and the divider operands.
  assign d1  = tvvc_pkg::plane_dist(prev_q, pass_q);
  assign d2  = tvvc_pkg::plane_dist(cur_q, pass_q);
  assign in1 = $signed(d1) > 32'sd0;
  assign in2 = $signed(d2) > 32'sd0;
  assign d1e = $signed({d1[31], d1});
  assign den = $signed({{2{d1[31]}}, d1}) - $signed({{2{d2[31]}}, d2});

  always_comb begin
    div_req.start = (state_q == EDGE) && (in1 != in2);
    div_req.num   = d1e[32] ? 33'(-d1e) : 33'(d1e);
    div_req.den   = den[33] ? 34'(-den) : 34'(den);
  end

  // Attribute interpolation operands.
  assign p1   = prev_q[k_q];
  assign p2   = cur_q[k_q];
  assign diff = $signed({p2[31], p2}) - $signed({p1[31], p1});
  assign mag  = diff[32] ? 33'(-diff) : 33'(diff);
  assign qv   = {1'b0, prod_q[49:tvvc_pkg::FRAC_BITS]};
  assign sum  = $signed({{3{p1[31]}}, p1}) + (neg_q ? -$signed(qv) : $signed(qv));

  // Fan order: vertex 0, then i, then i + 1.
  always_comb begin
    case (phase_q)
      2'd0:    fan_idx = '0;
      2'd1:    fan_idx = i_q;
      default: fan_idx = i_q + 4'd1;
    endcase
  end

  // Buffer port control.
  always_comb begin
    we    = 1'b0;
    waddr = tvvc_pkg::vert_addr(!src_q, cnt_q);
    wdata = cur_q;
    raddr = '0;
    case (state_q)
      IDLE: begin
        we    = accept;
        waddr = tvvc_pkg::vert_addr(1'b0, tvvc_pkg::idx_t'(vcount_q));
        wdata = in_vert;
      end
      W_XV: begin
        we    = room;
        wdata = x_q;
      end
      PUSH_CUR: begin
        we    = in2_q && room;
        raddr = tvvc_pkg::vert_addr(src_q, j_q + 4'd1);
      end
      P_RD0:   raddr = tvvc_pkg::vert_addr(src_q, '0);
      P_LD0:   raddr = tvvc_pkg::vert_addr(src_q, 4'd1);
      E_RD:    raddr = tvvc_pkg::vert_addr(src_q, fan_idx);
      default: raddr = '0;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      vcount_q    <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      j_q         <= '0;
      k_q         <= '0;
      i_q         <= '0;
      pass_q      <= '0;
      src_q       <= 1'b0;
      closing_q   <= 1'b0;
      in2_q       <= 1'b0;
      phase_q     <= '0;
      res_valid_q <= 1'b0;
      res_last_q  <= 1'b0;
    end else begin
      case (state_q)
        IDLE: begin
          if (accept) begin
            if (vcount_q == 2'd2) begin
              vcount_q <= '0;
              n_q      <= 4'd3;
              pass_q   <= '0;
              src_q    <= 1'b0;
              state_q  <= P_RD0;
            end else begin
              vcount_q <= vcount_q + 2'd1;
            end
          end
        end
        P_RD0: begin
          cnt_q <= '0;
          if (n_q == '0) begin
            state_q <= NEXT_PASS;
          end else begin
            state_q <= P_LD0;
          end
        end
        P_LD0: begin
          j_q       <= 4'd1;
          closing_q <= (n_q == 4'd1);
          state_q   <= (n_q == 4'd1) ? EDGE : P_LDC;
        end
        P_LDC: state_q <= EDGE;
        EDGE: begin
          in2_q   <= in2;
          k_q     <= '0;
          state_q <= (in1 != in2) ? DIV_WAIT : PUSH_CUR;
        end
        DIV_WAIT: begin
          if (div_rsp.done) begin
            state_q <= L_MUL;
          end
        end
        L_MUL: state_q <= L_ADD;
        L_ADD: begin
          if (k_q == tvvc_pkg::idx_t'(tvvc_pkg::VWORDS - 1)) begin
            state_q <= W_XV;
          end else begin
            k_q     <= k_q + 4'd1;
            state_q <= L_MUL;
          end
        end
        W_XV: begin
          if (room) begin
            cnt_q <= cnt_q + 4'd1;
          end
          state_q <= PUSH_CUR;
        end
        PUSH_CUR: begin
          if (in2_q && room) begin
            cnt_q <= cnt_q + 4'd1;
          end
          if (closing_q) begin
            state_q <= NEXT_PASS;
          end else if ((j_q + 4'd1) < n_q) begin
            j_q     <= j_q + 4'd1;
            state_q <= P_LDC;
          end else begin
            closing_q <= 1'b1;
            state_q   <= EDGE;
          end
        end
        NEXT_PASS: begin
          n_q   <= cnt_q;
          src_q <= !src_q;
          if (pass_q == tvvc_pkg::LAST_PLANE) begin
            i_q     <= 4'd1;
            phase_q <= '0;
            state_q <= (cnt_q >= 4'd3) ? E_RD : IDLE;
          end else begin
            pass_q  <= pass_q + 3'd1;
            state_q <= P_RD0;
          end
        end
        E_RD: state_q <= E_LD;
        E_LD: begin
          res_valid_q <= 1'b1;
          res_last_q  <= (phase_q == 2'd2) && (i_q == n_q - 4'd2);
          state_q     <= E_WAIT;
        end
        E_WAIT: begin
          if (res_o.ready) begin
            res_valid_q <= 1'b0;
            if (phase_q == 2'd2) begin
              phase_q <= '0;
              if (res_last_q) begin
                state_q <= IDLE;
              end else begin
                i_q     <= i_q + 4'd1;
                state_q <= E_RD;
              end
            end else begin
              phase_q <= phase_q + 2'd1;
              state_q <= E_RD;
            end
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  // Vertex, crossing and result registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      P_LD0: begin
        first_q <= rdata;
        prev_q  <= rdata;
        if (n_q == 4'd1) begin
          cur_q <= rdata;
        end
      end
      P_LDC: cur_q <= rdata;
      DIV_WAIT: begin
        if (div_rsp.done) begin
          t_q <= div_rsp.q;
        end
      end
      L_MUL: begin
        prod_q <= 50'(mag) * 50'(t_q);
        neg_q  <= diff[32];
      end
      L_ADD: x_q[k_q] <= tvvc_pkg::sat_word(sum);
      PUSH_CUR: begin
        prev_q <= cur_q;
        if (!closing_q && !((j_q + 4'd1) < n_q)) begin
          cur_q <= first_q;
        end
      end
      E_LD: res_q <= rdata;
      default: ;
    endcase
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.last_of_run = res_last_q;
  assign res_o.out_x       = res_q[tvvc_pkg::W_X];
  assign res_o.out_y       = res_q[tvvc_pkg::W_Y];
  assign res_o.out_z       = res_q[tvvc_pkg::W_Z];
  assign res_o.out_r       = res_q[tvvc_pkg::W_R][tvvc_pkg::COL_W-1:0];
  assign res_o.out_g       = res_q[tvvc_pkg::W_G][tvvc_pkg::COL_W-1:0];
  assign res_o.out_b       = res_q[tvvc_pkg::W_B][tvvc_pkg::COL_W-1:0];
  assign res_o.out_a       = res_q[tvvc_pkg::W_A][tvvc_pkg::COL_W-1:0];
  assign res_o.out_nx      = res_q[tvvc_pkg::W_NX];
  assign res_o.out_ny      = res_q[tvvc_pkg::W_NY];
  assign res_o.out_nz      = res_q[tvvc_pkg::W_NZ];

  // A result is never shown while a new vertex can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_o.valid |-> !vtx_i.ready)
    else $error("result shown while input is ready");

  // The divider answers only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   div_rsp.done |-> (state_q == DIV_WAIT))
    else $error("divider answer outside its wait state");

  // The output polygon never exceeds its buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cnt_q <= tvvc_pkg::idx_t'(tvvc_pkg::MAX_POLY_VERTS))
    else $error("polygon buffer overrun");

  // Emission only starts from a polygon of three vertices or more.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == E_RD) |-> (n_q >= 4'd3))
    else $error("fan started from a degenerate polygon");

endmodule

`default_nettype wire

[design/tvvc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tvvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[design/tvvc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module tvvc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tvvc_pkg::div_req_t req_i,
  output tvvc_pkg::div_rsp_t      rsp_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [3:0]            cnt_q;
  logic [33:0]           rem_q;
  logic [33:0]           den_q;
  tvvc_pkg::ratio_t      q_q;
  logic [34:0]           rem2;
  logic                  ge;

  // One restoring step: shift the remainder and try the subtraction.
  assign rem2 = {rem_q, 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= '0;
        if ({1'b0, req_i.num} >= req_i.den) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(tvvc_pkg::FRAC_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.num};
      den_q <= req_i.den;
      if ({1'b0, req_i.num} >= req_i.den) begin
        q_q <= tvvc_pkg::ONE_Q;
      end else begin
        q_q <= '0;
      end
    end else if (busy_q) begin
      rem_q <= ge ? 34'(rem2 - {1'b0, den_q}) : rem2[33:0];
      q_q   <= {q_q[tvvc_pkg::FRAC_BITS-1:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = q_q;

endmodule

`default_nettype wire
